/* sv/line_outcode_clipper_defines.svh */
// Assertion macros for the line clipper.
`ifndef LINE_OUTCODE_CLIPPER_DEFINES_SVH
`define LINE_OUTCODE_CLIPPER_DEFINES_SVH

// Checked on every edge outside reset.
`define LOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but also checked while reset is held.
`define LOC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/loc_pkg.sv */
package loc_pkg;

  localparam int COORD_W     = 32;
  localparam int T_FRAC_BITS = 30;
  localparam int T_W         = T_FRAC_BITS + 1;
  localparam int MAX_STEPS   = 4;
  localparam int CFG_IDX_W   = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Region code bits
  localparam logic [3:0] CODE_LEFT   = 4'b0001;
  localparam logic [3:0] CODE_RIGHT  = 4'b0010;
  localparam logic [3:0] CODE_BOTTOM = 4'b0100;
  localparam logic [3:0] CODE_TOP    = 4'b1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_ENABLE = 3'd0,
    CFG_VIEW_MIN_X  = 3'd1,
    CFG_VIEW_MAX_X  = 3'd2,
    CFG_VIEW_MIN_Y  = 3'd3,
    CFG_VIEW_MAX_Y  = 3'd4
  } cfg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

/* sv/loc_if.sv */
interface loc_in_if;
  logic            valid;
  logic            ready;
  loc_pkg::coord_t start_x;
  loc_pkg::coord_t start_y;
  loc_pkg::coord_t end_x;
  loc_pkg::coord_t end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface loc_out_if;
  logic            valid;
  logic            ready;
  loc_pkg::coord_t clipped_start_x;
  loc_pkg::coord_t clipped_start_y;
  loc_pkg::coord_t clipped_end_x;
  loc_pkg::coord_t clipped_end_y;
  logic            rejected;

  modport source (output valid, clipped_start_x, clipped_start_y, clipped_end_x,
                  clipped_end_y, rejected, input ready);
  modport sink   (input valid, clipped_start_x, clipped_start_y, clipped_end_x,
                  clipped_end_y, rejected, output ready);
endinterface

/* sv/line_outcode_clipper.sv */
// Cohen-Sutherland line clipper, signed Q16.16. One segment word in, one result
// word out. A small sequencer drives a shared datapath: per clip step a check
// state, a restoring divider that forms t (Q1.30), a shift-add multiplier that
// scales the other axis and an update state, for k = 0..4 clip steps per
// segment. With clip_enable low a segment goes from idle straight to the output
// stage. Input is not ready while a segment is in work; the finished result sits
// in an output register, so the next segment is taken while it waits. Rejected
// segments return zero coordinates with rejected set. Min y is the top edge.
`include "line_outcode_clipper_defines.svh"

module line_outcode_clipper (
  input  logic                          clk,
  input  logic                          rst_n,
  loc_in_if.sink                        in_w,
  loc_out_if.source                     out_w,
  input  logic                          cfg_we,
  input  logic [loc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [loc_pkg::COORD_W-1:0]   cfg_wdata
);

  localparam int W  = loc_pkg::COORD_W;
  localparam int TW = loc_pkg::T_W;

  // config
  logic            clip_en_r;
  loc_pkg::coord_t min_x_r, max_x_r, min_y_r, max_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_en_r <= 1'b0;
      min_x_r   <= '0;
      max_x_r   <= '0;
      min_y_r   <= '0;
      max_y_r   <= '0;
    end else if (cfg_we) begin
      unique case (loc_pkg::cfg_idx_t'(cfg_idx))
        loc_pkg::CFG_CLIP_ENABLE: clip_en_r <= cfg_wdata[0];
        loc_pkg::CFG_VIEW_MIN_X:  min_x_r   <= cfg_wdata;
        loc_pkg::CFG_VIEW_MAX_X:  max_x_r   <= cfg_wdata;
        loc_pkg::CFG_VIEW_MIN_Y:  min_y_r   <= cfg_wdata;
        loc_pkg::CFG_VIEW_MAX_Y:  max_y_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  function automatic logic [3:0] region(loc_pkg::coord_t x, loc_pkg::coord_t y,
                                        loc_pkg::coord_t mnx, loc_pkg::coord_t mxx,
                                        loc_pkg::coord_t mny, loc_pkg::coord_t mxy);
    logic [3:0] c;
    c = '0;
    if (x < mnx)      c = c | loc_pkg::CODE_LEFT;
    else if (x > mxx) c = c | loc_pkg::CODE_RIGHT;
    if (y < mny)      c = c | loc_pkg::CODE_TOP;
    else if (y > mxy) c = c | loc_pkg::CODE_BOTTOM;
    return c;
  endfunction

  function automatic logic [W:0] mag(logic signed [W:0] v);
    return v[W] ? (~v + 1'b1) : v;
  endfunction

  loc_pkg::state_t state_r, state_nxt;

  // endpoints under work
  loc_pkg::coord_t ax_r, ay_r, bx_r, by_r;
  logic [2:0]      step_r;
  logic            rej_r;
  // per-step context
  logic            side_b_r;   // moving endpoint b
  logic            clip_y_r;   // edge is horizontal: y set to bound
  loc_pkg::coord_t bound_r;
  loc_pkg::coord_t p0_r;       // other-axis start
  logic            neg_r;
  logic [W:0]      mag_r;
  logic [W:0]      den_r;
  logic [W+1:0]    rem_r;
  logic [TW-1:0]   q_r;
  logic [63:0]     acc_r;
  logic [4:0]      cnt_r;

  // output register
  logic            out_valid_r;
  loc_pkg::coord_t o_sx_r, o_sy_r, o_ex_r, o_ey_r;
  logic            o_rej_r;

  // check-cycle decode
  logic [3:0]        ca, cb, oc;
  logic              finish, clip_y;
  loc_pkg::coord_t   bnd, c0, c1, o0, o1;
  logic [W:0]        num_m, den_m, d_m;
  logic signed [W:0] d_s;

  always_comb begin
    ca     = region(ax_r, ay_r, min_x_r, max_x_r, min_y_r, max_y_r);
    cb     = region(bx_r, by_r, min_x_r, max_x_r, min_y_r, max_y_r);
    finish = ((ca | cb) == 4'd0) || ((ca & cb) != 4'd0) ||
             (step_r == 3'(loc_pkg::MAX_STEPS));
    oc     = (cb > ca) ? cb : ca;
    clip_y = (oc & (loc_pkg::CODE_TOP | loc_pkg::CODE_BOTTOM)) != 4'd0;
    priority if ((oc & loc_pkg::CODE_TOP) != 4'd0)    bnd = min_y_r;
    else if ((oc & loc_pkg::CODE_BOTTOM) != 4'd0)     bnd = max_y_r;
    else if ((oc & loc_pkg::CODE_LEFT) != 4'd0)       bnd = min_x_r;
    else                                              bnd = max_x_r;
    c0 = clip_y ? ay_r : ax_r;
    c1 = clip_y ? by_r : bx_r;
    o0 = clip_y ? ax_r : ay_r;
    o1 = clip_y ? bx_r : by_r;
    num_m = mag({bnd[W-1], bnd} - {c0[W-1], c0});
    den_m = mag({c1[W-1], c1} - {c0[W-1], c0});
    d_s   = {o1[W-1], o1} - {o0[W-1], o0};
    d_m   = mag(d_s);
  end

  // shared datapath pieces
  logic         ge;
  logic [W+1:0] rem_sub;
  logic [63:0]  rnd;
  logic [W:0]   qv;
  logic [W+1:0] newv;

  always_comb begin
    ge      = (rem_r >= {1'b0, den_r}) && (den_r != '0);
    rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    rnd     = acc_r + (64'd1 << (loc_pkg::T_FRAC_BITS - 1));
    qv      = rnd[loc_pkg::T_FRAC_BITS +: W+1];
    newv    = neg_r ? ({{2{p0_r[W-1]}}, p0_r} - {1'b0, qv})
                    : ({{2{p0_r[W-1]}}, p0_r} + {1'b0, qv});
  end

  logic in_acc, out_load;
  assign in_acc   = in_w.valid && in_w.ready;
  assign out_load = (state_r == loc_pkg::ST_DONE) && (!out_valid_r || out_w.ready);
  assign in_w.ready = (state_r == loc_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      loc_pkg::ST_IDLE:  if (in_acc) state_nxt = clip_en_r ? loc_pkg::ST_CHECK
                                                           : loc_pkg::ST_DONE;
      loc_pkg::ST_CHECK: state_nxt = finish ? loc_pkg::ST_DONE : loc_pkg::ST_DIV;
      loc_pkg::ST_DIV:   if (cnt_r == '0) state_nxt = loc_pkg::ST_MUL;
      loc_pkg::ST_MUL:   if (cnt_r == '0) state_nxt = loc_pkg::ST_UPD;
      loc_pkg::ST_UPD:   state_nxt = loc_pkg::ST_CHECK;
      loc_pkg::ST_DONE:  if (out_load) state_nxt = loc_pkg::ST_IDLE;
      default:           state_nxt = loc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= loc_pkg::ST_IDLE;
      step_r      <= '0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load)                        out_valid_r <= 1'b1;
      else if (out_valid_r && out_w.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        loc_pkg::ST_IDLE: begin
          step_r <= '0;
          rej_r  <= 1'b0;
        end
        loc_pkg::ST_CHECK: begin
          if (finish) rej_r <= ((ca | cb) != 4'd0);
          cnt_r <= 5'(TW - 1);
        end
        loc_pkg::ST_DIV: cnt_r <= (cnt_r == '0) ? 5'(TW - 1) : cnt_r - 1'b1;
        loc_pkg::ST_MUL: if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
        loc_pkg::ST_UPD: step_r <= step_r + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    unique case (state_r)
      loc_pkg::ST_IDLE: if (in_acc) begin
        ax_r <= in_w.start_x;
        ay_r <= in_w.start_y;
        bx_r <= in_w.end_x;
        by_r <= in_w.end_y;
      end
      loc_pkg::ST_CHECK: begin
        side_b_r <= (cb > ca);
        clip_y_r <= clip_y;
        bound_r  <= bnd;
        p0_r     <= o0;
        neg_r    <= d_s[W];
        mag_r    <= d_m;
        den_r    <= den_m;
        rem_r    <= {1'b0, (num_m > den_m) ? den_m : num_m};
        q_r      <= '0;
        acc_r    <= '0;
      end
      loc_pkg::ST_DIV: begin
        q_r   <= {q_r[TW-2:0], ge};
        rem_r <= {rem_sub[W:0], 1'b0};
      end
      loc_pkg::ST_MUL: begin
        acc_r <= {acc_r[62:0], 1'b0} + (q_r[TW-1] ? {{(63-W){1'b0}}, mag_r} : 64'd0);
        q_r   <= {q_r[TW-2:0], 1'b0};
      end
      loc_pkg::ST_UPD: begin
        if (side_b_r) begin
          bx_r <= clip_y_r ? newv[W-1:0] : bound_r;
          by_r <= clip_y_r ? bound_r : newv[W-1:0];
        end else begin
          ax_r <= clip_y_r ? newv[W-1:0] : bound_r;
          ay_r <= clip_y_r ? bound_r : newv[W-1:0];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      o_sx_r  <= rej_r ? '0 : ax_r;
      o_sy_r  <= rej_r ? '0 : ay_r;
      o_ex_r  <= rej_r ? '0 : bx_r;
      o_ey_r  <= rej_r ? '0 : by_r;
      o_rej_r <= rej_r;
    end
  end

  assign out_w.valid           = out_valid_r;
  assign out_w.clipped_start_x = o_sx_r;
  assign out_w.clipped_start_y = o_sy_r;
  assign out_w.clipped_end_x   = o_ex_r;
  assign out_w.clipped_end_y   = o_ey_r;
  assign out_w.rejected        = o_rej_r;

  `LOC_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_r, "output valid after reset")
  `LOC_ASSERT(a_state_onehot, $onehot(state_r), "state not one-hot")
  `LOC_ASSERT(a_step_bound, step_r <= 3'(loc_pkg::MAX_STEPS), "too many clip steps")
  `LOC_ASSERT(a_busy_after_accept, in_acc |=> state_r != loc_pkg::ST_IDLE, "idle after accept")
  `LOC_ASSERT(a_reject_zero, out_valid_r && o_rej_r |-> (o_sx_r == '0) && (o_ey_r == '0), "rejected word not zeroed")

endmodule

/* bench/line_outcode_clipper_tb.sv */
module line_outcode_clipper_tb;

  localparam int  STALL_LIMIT = 4000;  // idle cycles with no word moving
  localparam int  DRAIN_WAIT  = 300;   // covers the worst case segment
  localparam logic [31:0] ONE = 32'h0001_0000;  // 1.0 in Q16.16

  typedef struct packed {
    loc_pkg::coord_t sx, sy, ex, ey;
  } segment_t;

  typedef struct packed {
    loc_pkg::coord_t sx, sy, ex, ey;
    logic   rej;
  } clip_result_t;

  // Scoreboard: keeps its own copy of the viewport registers and predicts the
  // clipped segment for every accepted input word.
  class clip_scoreboard;
    bit         enable;
    longint     min_x, max_x, min_y, max_y;
    clip_result_t expected_q[$];
    int         errors;

    function void set_reg(loc_pkg::cfg_idx_t idx, logic [31:0] v);
      case (idx)
        loc_pkg::CFG_CLIP_ENABLE: enable = v[0];
        loc_pkg::CFG_VIEW_MIN_X:  min_x  = longint'(signed'(v));
        loc_pkg::CFG_VIEW_MAX_X:  max_x  = longint'(signed'(v));
        loc_pkg::CFG_VIEW_MIN_Y:  min_y  = longint'(signed'(v));
        loc_pkg::CFG_VIEW_MAX_Y:  max_y  = longint'(signed'(v));
        default: ;
      endcase
    endfunction

    function logic [3:0] outcode(longint x, longint y);
      logic [3:0] c;
      c = '0;
      if (x < min_x) c |= loc_pkg::CODE_LEFT;
      else if (x > max_x) c |= loc_pkg::CODE_RIGHT;
      if (y < min_y) c |= loc_pkg::CODE_TOP;
      else if (y > max_y) c |= loc_pkg::CODE_BOTTOM;
      return c;
    endfunction

    function logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // t in Q1.30 to reach the edge from p0 toward p1
    function logic [63:0] edge_fraction(longint bound, longint p0, longint p1);
      logic [63:0] num, den, t;
      num = magnitude(bound - p0);
      den = magnitude(p1 - p0);
      if (den == 0) return 0;
      if (num > den) num = den;
      t = (num << loc_pkg::T_FRAC_BITS) / den;
      if (t > (64'd1 << loc_pkg::T_FRAC_BITS)) t = 64'd1 << loc_pkg::T_FRAC_BITS;
      return t;
    endfunction

    // p0 + (p1-p0)*t, magnitude rounded half away from zero
    function longint lerp(longint p0, longint p1, logic [63:0] t);
      longint      d;
      logic [63:0] q;
      d = p1 - p0;
      q = (magnitude(d) * t + (64'd1 << (loc_pkg::T_FRAC_BITS - 1)))
          >> loc_pkg::T_FRAC_BITS;
      return (d < 0) ? p0 - longint'(q) : p0 + longint'(q);
    endfunction

    function void note_segment(segment_t s);
      longint       ax, ay, bx, by, nx, ny;
      logic [3:0]   ca, cb, oc;
      logic [63:0]  t;
      clip_result_t r;
      ax = longint'(s.sx); ay = longint'(s.sy);
      bx = longint'(s.ex); by = longint'(s.ey);
      r.rej = 1'b0;
      if (enable) begin
        ca = outcode(ax, ay);
        cb = outcode(bx, by);
        for (int step = 0; step < loc_pkg::MAX_STEPS; step++) begin
          if ((ca | cb) == 0 || (ca & cb) != 0) break;
          oc = (cb > ca) ? cb : ca;
          if (oc & loc_pkg::CODE_TOP) begin
            t = edge_fraction(min_y, ay, by); ny = min_y; nx = lerp(ax, bx, t);
          end else if (oc & loc_pkg::CODE_BOTTOM) begin
            t = edge_fraction(max_y, ay, by); ny = max_y; nx = lerp(ax, bx, t);
          end else if (oc & loc_pkg::CODE_LEFT) begin
            t = edge_fraction(min_x, ax, bx); nx = min_x; ny = lerp(ay, by, t);
          end else begin
            t = edge_fraction(max_x, ax, bx); nx = max_x; ny = lerp(ay, by, t);
          end
          if (oc == ca) begin
            ax = nx; ay = ny; ca = outcode(ax, ay);
          end else begin
            bx = nx; by = ny; cb = outcode(bx, by);
          end
        end
        r.rej = ((ca | cb) != 0);
      end
      if (r.rej) begin
        r.sx = '0; r.sy = '0; r.ex = '0; r.ey = '0;
      end else begin
        r.sx = loc_pkg::coord_t'(ax); r.sy = loc_pkg::coord_t'(ay);
        r.ex = loc_pkg::coord_t'(bx); r.ey = loc_pkg::coord_t'(by);
      end
      expected_q = {expected_q, r};
    endfunction

    function void check_result(clip_result_t got);
      clip_result_t w;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (got.sx !== w.sx) begin
        $error("clipped_start_x exp %0d got %0d", w.sx, got.sx); errors++;
      end
      if (got.sy !== w.sy) begin
        $error("clipped_start_y exp %0d got %0d", w.sy, got.sy); errors++;
      end
      if (got.ex !== w.ex) begin
        $error("clipped_end_x exp %0d got %0d", w.ex, got.ex); errors++;
      end
      if (got.ey !== w.ey) begin
        $error("clipped_end_y exp %0d got %0d", w.ey, got.ey); errors++;
      end
      if (got.rej !== w.rej) begin
        $error("rejected exp %0b got %0b", w.rej, got.rej); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [loc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [loc_pkg::COORD_W-1:0]   cfg_wdata;

  loc_in_if  in_w ();
  loc_out_if out_w ();

  line_outcode_clipper DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_w     (in_w.sink),
    .out_w    (out_w.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  clip_scoreboard sb = new();
  bit no_gaps;  // set for stretches where both sides run flat out
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one.
  function int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 200);
  endfunction

  // Result side: ready drops for random stretches.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_w.ready <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      out_w.ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_w.ready <= 1'b1;
      if (!no_gaps && $urandom_range(0, 9) == 0) stall_left <= pick_gap();
    end
  end

  // Result monitor; values are sampled before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && out_w.valid && out_w.ready)
      sb.check_result('{out_w.clipped_start_x, out_w.clipped_start_y,
                        out_w.clipped_end_x, out_w.clipped_end_y, out_w.rejected});
  end

  // Watchdog: too long without any word moving ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_w.valid && in_w.ready) || (out_w.valid && out_w.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(loc_pkg::cfg_idx_t idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // Viewport and enable in one go; the block must be idle here.
  task automatic set_viewport(bit en, logic [31:0] x0, logic [31:0] x1,
                              logic [31:0] y0, logic [31:0] y1);
    write_reg(loc_pkg::CFG_CLIP_ENABLE, {31'd0, en});
    write_reg(loc_pkg::CFG_VIEW_MIN_X, x0);
    write_reg(loc_pkg::CFG_VIEW_MAX_X, x1);
    write_reg(loc_pkg::CFG_VIEW_MIN_Y, y0);
    write_reg(loc_pkg::CFG_VIEW_MAX_Y, y1);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the input word until taken; valid stays up if no gap follows.
  task automatic send_segment(segment_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_w.valid   <= 1'b1;
    in_w.start_x <= s.sx;
    in_w.start_y <= s.sy;
    in_w.end_x   <= s.ex;
    in_w.end_y   <= s.ey;
    do @(posedge clk); while (!in_w.ready);
    sb.note_segment(s);
  endtask

  task automatic drain();
    in_w.valid <= 1'b0;
    @(posedge clk);
    wait (sb.expected_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Coordinate near [lo, hi] (out to about half the span beyond it), or a
  // fully random 32-bit value now and then.
  function loc_pkg::coord_t near_range(longint lo, longint hi);
    longint w, v;
    if ($urandom_range(0, 9) < 2) return loc_pkg::coord_t'($urandom);
    w = (hi > lo) ? hi - lo : lo - hi;
    w = 2 * w + 64;
    v = ((lo < hi) ? lo : hi) - w / 4 + longint'({$urandom, $urandom} % 64'(w));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return loc_pkg::coord_t'(v);
  endfunction

  task automatic random_segments(int n);
    segment_t s;
    repeat (n) begin
      // flip between bursty and flat-out stretches
      if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
      s.sx = near_range(sb.min_x, sb.max_x);
      s.sy = near_range(sb.min_y, sb.max_y);
      s.ex = near_range(sb.min_x, sb.max_x);
      s.ey = near_range(sb.min_y, sb.max_y);
      send_segment(s);
    end
    no_gaps = 1'b0;
  endtask

  localparam logic [31:0] XMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] XMIN = 32'h8000_0000;

  initial begin
    segment_t d[$];
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    in_w.valid  = 1'b0;
    in_w.start_x = '0; in_w.start_y = '0; in_w.end_x = '0; in_w.end_y = '0;
    no_gaps     = 1'b0;
    quiet_cycles = 0;
    sb.set_reg(loc_pkg::CFG_CLIP_ENABLE, 0);
    sb.set_reg(loc_pkg::CFG_VIEW_MIN_X, 0); sb.set_reg(loc_pkg::CFG_VIEW_MAX_X, 0);
    sb.set_reg(loc_pkg::CFG_VIEW_MIN_Y, 0); sb.set_reg(loc_pkg::CFG_VIEW_MAX_Y, 0);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config: clipping off, words pass unchanged.
    send_segment('{XMAX, XMIN, XMIN, XMAX});
    send_segment('{32'hFFFF_FFFF, 32'h0, 32'h5555_5555, 32'hAAAA_AAAA});
    drain();

    // Viewport x in [-100, 100], y in [-50, 50].
    set_viewport(1'b1, -100 * ONE, 100 * ONE, -50 * ONE, 50 * ONE);
    d = '{
      '{ 32'(-10 * ONE), 32'(5 * ONE),   32'(20 * ONE),  32'(-7 * ONE)},  // inside
      '{ 32'(-200 * ONE), 32'(0),        32'(-150 * ONE), 32'(10 * ONE)}, // all left
      '{ 32'(150 * ONE), 32'(0),         32'(300 * ONE), 32'(-10 * ONE)}, // all right
      '{ 32'(0),         32'(-80 * ONE), 32'(5 * ONE),   32'(-60 * ONE)}, // all top
      '{ 32'(0),         32'(80 * ONE),  32'(5 * ONE),   32'(60 * ONE)},  // all bottom
      '{ 32'(0),         32'(0),         32'(10 * ONE),  32'(-90 * ONE)}, // top cut
      '{ 32'(0),         32'(0),         32'(-10 * ONE), 32'(90 * ONE)},  // bottom cut
      '{ 32'(-300 * ONE), 32'(3 * ONE),  32'(0),         32'(0)},         // left cut
      '{ 32'(0),         32'(0),         32'(250 * ONE), 32'(7 * ONE)},   // right cut
      '{ 32'(-300 * ONE), 32'(-90 * ONE), 32'(300 * ONE), 32'(90 * ONE)}, // both ends cut
      '{ 32'(-130 * ONE), 32'(-70 * ONE), 32'(140 * ONE), 32'(75 * ONE)}, // corner to corner
      '{ 32'(-120 * ONE), 32'(40 * ONE), 32'(-60 * ONE), 32'(80 * ONE)},  // misses corner
      '{ XMIN,           XMIN,           XMAX,           XMAX},           // full range diag
      '{ XMAX,           32'(0),         XMIN,           32'(0)},         // horizontal
      '{ 32'(1),         XMIN,           32'(1),         XMAX},           // vertical
      '{ 32'(500 * ONE), 32'(500 * ONE), 32'(500 * ONE), 32'(500 * ONE)}, // point outside
      '{ 32'(100 * ONE), 32'(-50 * ONE), 32'(-100 * ONE), 32'(50 * ONE)}, // on the edges
      '{ 32'(-99 * ONE), 32'(-60 * ONE), 32'(-101 * ONE), 32'(-40 * ONE)} // near corner
    };
    foreach (d[i]) send_segment(d[i]);
    random_segments(330);
    drain();

    // Widest viewport: nothing is ever outside.
    set_viewport(1'b1, XMIN, XMAX, XMIN, XMAX);
    random_segments(100);
    drain();

    // Inverted viewport: clip loop can run out of steps.
    set_viewport(1'b1, 40 * ONE, -40 * ONE, 25 * ONE, -30 * ONE);
    random_segments(150);
    drain();

    // Small off-center viewport with fractional bounds.
    set_viewport(1'b1, 32'h0003_8000, 32'h0009_4001, 32'hFFF8_C000, 32'hFFFD_2000);
    random_segments(300);
    drain();

    // Clipping off again, nonzero bounds left in place.
    set_viewport(1'b0, -7 * ONE, 7 * ONE, -3 * ONE, 9 * ONE);
    random_segments(80);
    drain();

    // Degenerate zero-size viewport at the origin.
    set_viewport(1'b1, 0, 0, 0, 0);
    random_segments(130);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* line_outcode_clipper.f */
+incdir+sv
sv/loc_pkg.sv
sv/loc_if.sv
sv/line_outcode_clipper.sv
bench/line_outcode_clipper_tb.sv
